// File: rtl/rps_pkg.sv
// Shared constants, word types and symbol arithmetic for the rotor cipher.
package rps_pkg;

    localparam int ALPHA   = 14;
    localparam int SYM_W   = 4;
    localparam int ADDR_W  = $clog2(ALPHA * ALPHA);
    localparam int CNT_W   = $clog2(ALPHA + 1);
    localparam int SPIN_W  = 12;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ROUND = 2'd1;
    localparam logic [1:0] CMD_ENC   = 2'd2;
    localparam logic [1:0] CMD_DEC   = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] key_row;
        logic [3:0] key_column;
        logic [3:0] key_value;
        logic [7:0] round_index;
        logic [3:0] symbol_in;
    } in_word_t;

    typedef struct packed {
        logic [3:0] symbol_out;
        logic       no_preimage;
    } out_word_t;

    // reduce any 4-bit value into the alphabet
    function automatic logic [SYM_W-1:0] mod_sym(input logic [3:0] v);
        logic [4:0] t;
        t = {1'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (t >= 5'(ALPHA)) t = t - 5'(ALPHA);
        end
        return t[SYM_W-1:0];
    endfunction

    // sum of two in-range symbols, modulo the alphabet
    function automatic logic [SYM_W-1:0] mod_add(input logic [SYM_W-1:0] a,
                                                 input logic [SYM_W-1:0] b);
        logic [SYM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SYM_W+1)'(ALPHA)) s = s - (SYM_W+1)'(ALPHA);
        return s[SYM_W-1:0];
    endfunction

endpackage

// File: rtl/rotor_permutation_stream_cipher.sv
// Top level of the rotor permutation stream cipher: sequencer around the key RAM.
//
// Usage: a request word enters on req_valid/req_stall, one response word leaves
// on rsp_valid/rsp_stall for every request. spin_factor is written through
// cfg_we/cfg_wdata while the block is idle.
// Steps per request on the single read port of the key RAM (one read per cycle):
//   load key entry, or begin round with zero spins: straight to the response.
//   encrypt: one rotor chain, then a row update of the offsets, then the response.
//   decrypt: 14 chains (one per symbol), then a row update, then the response.
//   begin round: round_index * spin_factor spins of 14 chains and an offset add.
// The block works on one request at a time; req_stall is high while busy.
// A finished response sits in the output register, so the next request may be
// taken while the receiver holds rsp_stall high; the block then waits in its
// last step until the output register frees up.
// Reset clears the rotor offsets, spin_factor and all control state. The key
// RAM is not cleared: load every entry before it is used.
module rotor_permutation_stream_cipher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_wdata,
    input  logic              req_valid,
    output logic              req_stall,
    input  rps_pkg::in_word_t req_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rps_pkg::out_word_t rsp_word
);
    import rps_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHAIN = 5'b00010,
        ST_UPD   = 5'b00100,
        ST_SPIN  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t           state_reg;
    logic [3:0]       spin_factor_reg;
    logic [SYM_W-1:0] off_reg [ALPHA];
    logic [SYM_W-1:0] perm_reg [ALPHA];
    logic [1:0]       cmd_reg;
    logic [SYM_W-1:0] tgt_reg;       // encrypt start symbol / decrypt ciphertext
    logic             full_reg;      // build the whole permutation
    logic [SPIN_W-1:0] spins_reg;
    logic [CNT_W-1:0] rot_reg;       // next rotor to issue, or update column
    logic [SYM_W-1:0] sym_reg;       // symbol whose chain is running
    logic             first_reg;
    logic             found_reg;
    logic [SYM_W-1:0] res_reg;
    logic             rsp_valid_reg;
    out_word_t        rsp_word_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [SYM_W-1:0]  ram_wdata;
    logic [SYM_W-1:0]  ram_rdata;

    logic [SYM_W-1:0]  x_cur;
    logic [SYM_W-1:0]  rot_idx;
    logic [SYM_W-1:0]  col;
    logic [ADDR_W-1:0] chain_addr;
    logic [ADDR_W-1:0] upd_addr;
    logic [SYM_W-1:0]  row_sel;
    logic              accept;
    logic              out_free;

    rps_ram #(.WIDTH(SYM_W), .DEPTH(ALPHA * ALPHA)) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // chain step: symbol entering rotor rot_reg comes from the RAM after the first
    assign x_cur   = first_reg ? (full_reg ? sym_reg : tgt_reg) : ram_rdata;
    assign rot_idx = (rot_reg < CNT_W'(ALPHA)) ? rot_reg[SYM_W-1:0] : '0;
    assign col     = mod_add(off_reg[rot_idx], x_cur);
    assign chain_addr = ADDR_W'(32'(rot_idx) * ALPHA + 32'(col));

    // offset update reads the key row of the ciphertext symbol
    assign row_sel  = (cmd_reg == CMD_ENC) ? res_reg : tgt_reg;
    assign upd_addr = ADDR_W'(32'(row_sel) * ALPHA + 32'(rot_idx));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = mod_sym(req_word.key_value);
        ram_addr  = chain_addr;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_addr = ADDR_W'(32'(req_word.key_row[SYM_W-1:0]) * ALPHA
                                   + 32'(req_word.key_column[SYM_W-1:0]));
                ram_we   = accept && (req_word.command == CMD_LOAD)
                           && (req_word.key_row < 4'(ALPHA))
                           && (req_word.key_column < 4'(ALPHA));
            end
            ST_UPD:  ram_addr = upd_addr;
            ST_CHAIN, ST_SPIN, ST_DONE: ram_addr = chain_addr;
            default: ram_addr = chain_addr;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            spin_factor_reg <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_word_reg    <= '0;
            cmd_reg         <= CMD_LOAD;
            tgt_reg         <= '0;
            full_reg        <= 1'b0;
            spins_reg       <= '0;
            rot_reg         <= '0;
            sym_reg         <= '0;
            first_reg       <= 1'b0;
            found_reg       <= 1'b0;
            res_reg         <= '0;
            for (int i = 0; i < ALPHA; i++)
            begin
                off_reg[i]  <= '0;
                perm_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we) spin_factor_reg <= cfg_wdata;

            // raise valid when a response is issued, drop it once taken
            if (state_reg == ST_DONE && out_free) rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)                   rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= req_word.command;
                        tgt_reg   <= mod_sym(req_word.symbol_in);
                        rot_reg   <= '0;
                        sym_reg   <= '0;
                        first_reg <= 1'b1;
                        found_reg <= 1'b0;
                        res_reg   <= '0;
                        spins_reg <= SPIN_W'(req_word.round_index) * SPIN_W'(spin_factor_reg);
                        full_reg  <= (req_word.command != CMD_ENC);
                        unique case (req_word.command)
                            CMD_LOAD: state_reg <= ST_DONE;
                            CMD_ROUND:
                            begin
                                for (int i = 0; i < ALPHA; i++) off_reg[i] <= '0;
                                if (req_word.round_index == '0 || spin_factor_reg == '0)
                                    state_reg <= ST_DONE;
                                else
                                    state_reg <= ST_CHAIN;
                            end
                            CMD_ENC, CMD_DEC: state_reg <= ST_CHAIN;
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_CHAIN:
                begin
                    if (rot_reg < CNT_W'(ALPHA))
                    begin
                        first_reg <= 1'b0;
                        rot_reg   <= rot_reg + 1'b1;
                    end
                    else
                    begin
                        // end of chain: x_cur is the image of the start symbol
                        perm_reg[sym_reg] <= x_cur;
                        if (!full_reg) res_reg <= x_cur;
                        else if (!found_reg && x_cur == tgt_reg)
                        begin
                            found_reg <= 1'b1;
                            res_reg   <= sym_reg;
                        end
                        rot_reg   <= '0;
                        first_reg <= 1'b1;
                        if (full_reg && sym_reg != SYM_W'(ALPHA - 1))
                            sym_reg <= sym_reg + 1'b1;
                        else if (cmd_reg == CMD_ROUND)
                            state_reg <= ST_SPIN;
                        else
                            state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    if (rot_reg != '0)
                        off_reg[rot_reg[SYM_W-1:0] - 1'b1] <=
                            mod_add(off_reg[rot_reg[SYM_W-1:0] - 1'b1], ram_rdata);
                    if (rot_reg == CNT_W'(ALPHA))
                        state_reg <= ST_DONE;
                    else
                        rot_reg <= rot_reg + 1'b1;
                end
                ST_SPIN:
                begin
                    // add the whole permutation to the offsets
                    for (int i = 0; i < ALPHA; i++)
                        off_reg[i] <= mod_add(off_reg[i], perm_reg[i]);
                    spins_reg <= spins_reg - 1'b1;
                    sym_reg   <= '0;
                    rot_reg   <= '0;
                    first_reg <= 1'b1;
                    if (spins_reg == SPIN_W'(1)) state_reg <= ST_DONE;
                    else                         state_reg <= ST_CHAIN;
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        rsp_word_reg.symbol_out <= ((cmd_reg == CMD_ENC) ||
                            (cmd_reg == CMD_DEC && found_reg)) ? res_reg : '0;
                        rsp_word_reg.no_preimage <= (cmd_reg == CMD_DEC) && !found_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;
endmodule

// File: rtl/rps_ram.sv
// Generic single-port RAM with registered read.
module rps_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 196
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// File: sim/rotor_permutation_stream_cipher_test.sv
// Testbench for the rotor permutation stream cipher: directed and random words checked on the fly.
`timescale 1ns / 100ps

module rotor_permutation_stream_cipher_test;
    import rps_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [3:0] cfg_wdata;
    logic      req_valid;
    logic      req_stall;
    in_word_t  req_word;
    logic      rsp_valid;
    logic      rsp_stall;
    out_word_t rsp_word;

    rotor_permutation_stream_cipher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    // Shadow copy of the cipher state, kept in step with every accepted request word.
    logic [3:0] key_shadow [ALPHA*ALPHA];
    logic [3:0] offset_shadow [ALPHA];
    logic [3:0] perm_shadow [ALPHA];
    logic [3:0] spin_shadow;

    out_word_t cipher_q [$];   // responses still owed by the block, oldest first
    int        err_count;
    int        words_sent;
    int        words_checked;
    bit        no_idle;        // set to run a stretch with no gaps and no stalls

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [3:0] wrap(input int v);
        return 4'(v % ALPHA);
    endfunction

    // Rebuild the symbol permutation from the current rotor offsets.
    function automatic void build_perm();
        int x;
        for (int s = 0; s < ALPHA; s++)
        begin
            x = s;
            for (int r = 0; r < ALPHA; r++)
                x = wrap(key_shadow[r*ALPHA + wrap(offset_shadow[r] + x)]);
            perm_shadow[s] = 4'(x);
        end
    endfunction

    // Advance every offset by the matching entry of a key row.
    function automatic void advance_by_row(input int row);
        for (int i = 0; i < ALPHA; i++)
            offset_shadow[i] = wrap(offset_shadow[i] + wrap(key_shadow[row*ALPHA + i]));
    endfunction

    function automatic out_word_t predict_cipher(input in_word_t w);
        out_word_t o;
        int        sym;
        int        spins;
        bit        found;
        o   = '0;
        sym = wrap(w.symbol_in);
        case (w.command)
            CMD_LOAD:
                if (w.key_row < ALPHA && w.key_column < ALPHA)
                    key_shadow[w.key_row*ALPHA + w.key_column] = wrap(w.key_value);
            CMD_ROUND:
            begin
                spins = w.round_index * spin_shadow;
                for (int i = 0; i < ALPHA; i++)
                    offset_shadow[i] = '0;
                for (int n = 0; n < spins; n++)
                begin
                    build_perm();
                    for (int i = 0; i < ALPHA; i++)
                        offset_shadow[i] = wrap(offset_shadow[i] + perm_shadow[i]);
                end
            end
            CMD_ENC:
            begin
                build_perm();
                o.symbol_out = perm_shadow[sym];
                advance_by_row(o.symbol_out);
            end
            default:
            begin
                build_perm();
                found = 1'b0;
                for (int d = 0; d < ALPHA; d++)
                begin
                    if (!found && perm_shadow[d] == sym)
                    begin
                        found        = 1'b1;
                        o.symbol_out = 4'(d);
                    end
                end
                advance_by_row(sym);
                o.no_preimage = !found;
            end
        endcase
        return o;
    endfunction

    // Present one word, hold it until accepted, then log the expected response.
    // Valid stays high afterwards; drop_valid lowers it.
    task automatic send_word(input in_word_t w);
        bit taken;
        if (!no_idle && $urandom_range(99) < 32)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 32);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
        cipher_q.push_back(predict_cipher(w));
        words_sent++;
    endtask

    task automatic drop_valid();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off until every owed response has come back.
    task automatic drain();
        drop_valid();
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_spin(input logic [3:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        spin_shadow = v;
        @(posedge clk);
    endtask

    function automatic in_word_t make_word(input logic [1:0] cmd, input int row, input int col,
                                           input int val, input int rnd, input int sym);
        in_word_t w;
        w.command     = cmd;
        w.key_row     = 4'(row);
        w.key_column  = 4'(col);
        w.key_value   = 4'(val);
        w.round_index = 8'(rnd);
        w.symbol_in   = 4'(sym);
        return w;
    endfunction

    // Load a full key: each row a rotated, scrambled permutation so every entry is defined.
    task automatic test_key_load();
        for (int r = 0; r < ALPHA; r++)
            for (int c = 0; c < ALPHA; c++)
                send_word(make_word(CMD_LOAD, r, c, ((c * 3) + r * 5 + 1) % ALPHA, 0, 0));
        // out-of-range row and column: drop silently
        send_word(make_word(CMD_LOAD, 15, 0, 7, 0, 0));
        send_word(make_word(CMD_LOAD, 0, 14, 9, 0, 0));
        // value above the alphabet wraps around
        send_word(make_word(CMD_LOAD, 13, 13, 15, 0, 0));
    endtask

    task automatic test_encrypt_decrypt();
        send_word(make_word(CMD_ENC, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_ENC, 0, 0, 0, 0, 13));
        send_word(make_word(CMD_ENC, 15, 15, 15, 255, 15));  // symbol wraps
        send_word(make_word(CMD_DEC, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_DEC, 0, 0, 0, 0, 13));
        send_word(make_word(CMD_DEC, 15, 15, 15, 255, 14));
    endtask

    // A row of repeated symbols gives a permutation with holes: hits both
    // smallest-preimage and no-preimage decrypts.
    task automatic test_broken_row();
        for (int c = 0; c < ALPHA; c++)
            send_word(make_word(CMD_LOAD, 7, c, c / 2, 0, 0));
        for (int s = 0; s < 6; s++)
            send_word(make_word(CMD_DEC, 0, 0, 0, 0, s * 3));
        send_word(make_word(CMD_ENC, 0, 0, 0, 0, 5));
    endtask

    task automatic test_rounds();
        write_spin(4'd0);
        send_word(make_word(CMD_ROUND, 0, 0, 0, 255, 0));     // zero spins, factor zero
        send_word(make_word(CMD_ENC, 0, 0, 0, 0, 4));
        write_spin(4'd15);
        send_word(make_word(CMD_ROUND, 0, 0, 0, 0, 0));       // zero spins, index zero
        send_word(make_word(CMD_ROUND, 0, 0, 0, 1, 0));       // top factor
        send_word(make_word(CMD_DEC, 0, 0, 0, 0, 9));
        write_spin(4'd1);
        send_word(make_word(CMD_ROUND, 0, 0, 0, 255, 0));     // top index
        send_word(make_word(CMD_ENC, 0, 0, 0, 0, 11));
    endtask

    task automatic random_phase(input int count, input logic [3:0] spin, input int rnd_max);
        in_word_t w;
        int       pick;
        write_spin(spin);
        for (int n = 0; n < count; n++)
        begin
            w    = in_word_t'($urandom);
            pick = $urandom_range(99);
            if (pick < 40)
                w.command = CMD_ENC;
            else if (pick < 72)
                w.command = CMD_DEC;
            else if (pick < 90)
                w.command = CMD_LOAD;
            else
            begin
                w.command = CMD_ROUND;
                if (rnd_max < 255)
                    w.round_index = 8'($urandom_range(rnd_max));
            end
            send_word(w);
            // pause the source once until the block has caught up
            if (n == count / 2 && spin == 4'd2)
                drain();
        end
    endtask

    // Receiver: stall at random, check every response against the oldest expectation.
    always @(posedge clk)
        rsp_stall <= !no_idle && ($urandom_range(99) < 32);

    always @(negedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (cipher_q.size() == 0)
            begin
                $error("response with nothing expected: symbol_out %0d", rsp_word.symbol_out);
                err_count++;
            end
            else
            begin
                if (rsp_word.symbol_out !== cipher_q[0].symbol_out)
                begin
                    $error("symbol_out expected %0d actual %0d",
                           cipher_q[0].symbol_out, rsp_word.symbol_out);
                    err_count++;
                end
                if (rsp_word.no_preimage !== cipher_q[0].no_preimage)
                begin
                    $error("no_preimage expected %0d actual %0d",
                           cipher_q[0].no_preimage, rsp_word.no_preimage);
                    err_count++;
                end
                void'(cipher_q.pop_front());
                words_checked++;
            end
        end
    end

    initial
    begin
        #200ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        req_valid   = 1'b0;
        req_word    = '0;
        no_idle     = 1'b0;
        err_count   = 0;
        words_sent  = 0;
        words_checked = 0;
        spin_shadow = '0;
        for (int i = 0; i < ALPHA; i++)
        begin
            offset_shadow[i] = '0;
            perm_shadow[i]   = '0;
        end
        for (int i = 0; i < ALPHA*ALPHA; i++)
            key_shadow[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_key_load();
        test_encrypt_decrypt();
        test_broken_row();
        test_rounds();
        random_phase(340, 4'd2, 3);
        random_phase(290, 4'd0, 255);
        no_idle = 1'b1;
        random_phase(250, 4'd1, 5);
        no_idle = 1'b0;
        random_phase(250, 4'd15, 1);
        random_phase(135, 4'd3, 2);

        drain();
        repeat (20) @(posedge clk);
        $display("Run covered %0d request words and %0d checked responses", words_sent,
                 words_checked);
        $display("across key loads, rounds at several spin factors, encrypts and decrypts.");
        if (err_count == 0 && cipher_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
